>>> rtl/core/dbrle_pkg.sv
// Shared types and constants for the double-byte run-length frame decoder.
package dbrle_pkg;

	// Source sector and frame line length in bytes, and its shift amount.
	localparam int unsigned LINE_BYTES    = 256;
	localparam int unsigned LINE_SHIFT    = 8;
	localparam int unsigned MAX_LINES_DEF = 212;

	// Marker bytes in the source stream.
	localparam logic [7:0] EOF_LEAD    = 8'hFF;
	localparam logic [7:0] EOF_TAIL    = 8'h1A;
	localparam logic [7:0] SECTOR_MARK = 8'h01;
	localparam logic [7:0] COUNT_NOP   = 8'd2;

	// Line count thresholds and the image heights they select.
	localparam int unsigned LINES_LOW  = 150;
	localparam int unsigned LINES_MID  = 190;
	localparam int unsigned LINES_HIGH = 200;
	localparam logic [7:0]  HEIGHT_LOW  = 8'd140;
	localparam logic [7:0]  HEIGHT_MID  = 8'd180;
	localparam logic [7:0]  HEIGHT_HIGH = 8'd192;
	localparam logic [7:0]  HEIGHT_FULL = 8'd200;
	localparam logic [3:0]  LEFT_SHIFT_PIX = 4'd8;

	typedef struct packed {
		logic [7:0] cur_byte;
		logic [7:0] ahead_one;
		logic [7:0] ahead_two;
		logic [7:0] ahead_three;
		logic       final_byte;
	} src_item_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_addr;
		logic [7:0]  fill_len;
		logic [7:0]  fill_value;
		logic        finished;
		logic [7:0]  lines_used;
		logic [7:0]  image_height;
		logic [3:0]  left_offset;
	} dec_result_t;

endpackage

>>> rtl/core/double_byte_rle_frame_decoder_unit.sv
// Top level of the double-byte run-length frame decoder with its stream ports.
//
// The block takes one source byte per input beat, together with the next three
// source bytes as lookahead and a flag that marks the last byte, and emits at
// most one frame write command per beat: a start address, a run length (1 for
// a literal byte) and a fill value. A byte equal to its predecessor arms a
// repeat, and the byte after it is a count: values above two fill count-2
// copies, zero and one step the write pointer back by two or one bytes
// (saturating at zero), and two does nothing. The repeat state resets at every
// 256-byte source sector. Decoding ends on FF 1A, on 01 01 01 01 at a sector
// start, on the last byte, or when the frame is full; the ending beat has
// tlast set and carries the line count, image height and left offset. Beats
// after the end are consumed silently until reset. Each input beat passes through
// an input register and a result register, and the block sustains one beat per
// clock while m_tready is not held low; the decoder state update for a byte is
// combinational from the state registers, which is what allows this rate.
module double_byte_rle_frame_decoder_unit #(
	parameter int unsigned MAX_LINES = dbrle_pkg::MAX_LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] cur_byte, [15:8] ahead_one, [23:16] ahead_two, [31:24] ahead_three
	input  logic [31:0] s_tdata,
	// final_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] write_addr, [23:16] fill_len, [31:24] fill_value, [39:32] lines_used,
	// [47:40] image_height, [51:48] left_offset, [55:52] zero
	output logic [55:0] m_tdata,
	// write_valid
	output logic        m_tuser,
	// finished
	output logic        m_tlast
);

	dbrle_pkg::src_item_t   item_s1;
	logic                   valid_s1;
	dbrle_pkg::dec_result_t res;
	dbrle_pkg::dec_result_t res_s2;
	logic                   has_res;
	logic                   advance;
	logic                   step;

	// The result register can take a new beat when it is empty or being drained.
	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cur_byte    <= s_tdata[7:0];
			item_s1.ahead_one   <= s_tdata[15:8];
			item_s1.ahead_two   <= s_tdata[23:16];
			item_s1.ahead_three <= s_tdata[31:24];
			item_s1.final_byte  <= s_tlast;
		end
	end

	dbrle_core #(
		.MAX_LINES(MAX_LINES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res),
		.has_res(has_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= step && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {4'd0, res_s2.left_offset, res_s2.image_height, res_s2.lines_used,
		res_s2.fill_value, res_s2.fill_len, res_s2.write_addr};
	assign m_tuser = res_s2.write_valid;
	assign m_tlast = res_s2.finished;

`ifndef SYNTH
	// A beat that writes nothing exists only to report the end of decoding.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result beat carries neither a write nor the finish");

	// Once the finishing beat is taken, no further results appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result beat after decoding finished");

	// Every write covers at least one frame byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[23:16] != 8'd0)
		else $error("write beat with zero length");
`endif

endmodule

>>> rtl/core/dbrle_core.sv
// Decoder state and the combinational step logic for one source byte.
module dbrle_core #(
	parameter int unsigned MAX_LINES = dbrle_pkg::MAX_LINES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  dbrle_pkg::src_item_t   item,
	output dbrle_pkg::dec_result_t res,
	output logic                   has_res
);

	localparam int unsigned FRAME_BYTES = dbrle_pkg::LINE_BYTES * MAX_LINES;
	localparam int unsigned PTR_W       = $clog2(FRAME_BYTES + 1);
	localparam int unsigned LINES_W     = PTR_W - dbrle_pkg::LINE_SHIFT;
	localparam logic [PTR_W-1:0] FRAME_END = PTR_W'(FRAME_BYTES);

	logic [7:0]       sector_q;
	logic [7:0]       prev_q;
	logic             rep_q;
	logic [PTR_W-1:0] wp_q;
	logic             stop_q;
	logic [31:0]      ff_q;

	logic [7:0]       sector_n;
	logic [7:0]       prev_n;
	logic             rep_n;
	logic [PTR_W-1:0] wp_n;
	logic             stop_n;
	logic [31:0]      ff_n;

	logic             at_start;
	logic             sector_end;
	logic             eof_mark;
	logic             rep_eff;
	logic [7:0]       prev_eff;
	logic [PTR_W-1:0] room;
	logic [7:0]       cnt_m2;
	logic [7:0]       run_len;
	logic [PTR_W-1:0] back;
	logic [PTR_W:0]   end_sum;
	logic [LINES_W-1:0] lines;
	logic             fin;

	always_comb begin
		at_start   = (sector_q == 8'd0);
		sector_end = at_start && (item.cur_byte == dbrle_pkg::SECTOR_MARK)
			&& (item.ahead_one == dbrle_pkg::SECTOR_MARK)
			&& (item.ahead_two == dbrle_pkg::SECTOR_MARK)
			&& (item.ahead_three == dbrle_pkg::SECTOR_MARK);
		eof_mark   = (item.cur_byte == dbrle_pkg::EOF_LEAD)
			&& (item.ahead_one == dbrle_pkg::EOF_TAIL);
		rep_eff    = at_start ? 1'b0 : rep_q;
		prev_eff   = at_start ? ~item.cur_byte : prev_q;
		room       = FRAME_END - wp_q;
		cnt_m2     = item.cur_byte - dbrle_pkg::COUNT_NOP;
		run_len    = (PTR_W'(cnt_m2) > room) ? room[7:0] : cnt_m2;
		back       = (item.cur_byte == 8'd0) ? PTR_W'(2) : PTR_W'(1);

		sector_n = sector_q;
		prev_n   = prev_q;
		rep_n    = rep_q;
		wp_n     = wp_q;
		stop_n   = stop_q;
		ff_n     = ff_q;
		fin      = 1'b0;
		res      = '0;

		if (!stop_q) begin
			if (sector_end) begin
				fin = 1'b1;
			end else begin
				rep_n  = rep_eff;
				prev_n = prev_eff;
				if (eof_mark) begin
					fin = 1'b1;
				end else begin
					if (rep_eff) begin
						// The count byte after a doubled byte.
						rep_n = 1'b0;
						if (item.cur_byte > dbrle_pkg::COUNT_NOP) begin
							res.write_valid = 1'b1;
							res.write_addr  = 16'(wp_q);
							res.fill_len    = run_len;
							res.fill_value  = prev_eff;
							wp_n            = wp_q + PTR_W'(run_len);
						end else if (item.cur_byte < dbrle_pkg::COUNT_NOP) begin
							wp_n = (wp_q >= back) ? wp_q - back : '0;
						end
						prev_n = ~item.ahead_one;
					end else begin
						rep_n           = (item.cur_byte == prev_eff);
						prev_n          = item.cur_byte;
						res.write_valid = 1'b1;
						res.write_addr  = 16'(wp_q);
						res.fill_len    = 8'd1;
						res.fill_value  = item.cur_byte;
						wp_n            = wp_q + PTR_W'(1);
					end
					sector_n = sector_q + 8'd1;
					if (wp_n >= FRAME_END || item.final_byte) begin
						fin = 1'b1;
					end
				end
			end
		end

		// Track the first four frame bytes for the left offset decision.
		end_sum = {1'b0, wp_q} + (PTR_W+1)'(res.fill_len);
		for (int a = 0; a < 4; a++) begin
			if (res.write_valid && (wp_q <= PTR_W'(a)) && ((PTR_W+1)'(a) < end_sum)) begin
				ff_n[a*8 +: 8] = res.fill_value;
			end
		end

		lines = wp_n[PTR_W-1:dbrle_pkg::LINE_SHIFT];
		if (fin) begin
			stop_n         = 1'b1;
			res.finished   = 1'b1;
			res.lines_used = 8'(lines);
			if (lines < LINES_W'(dbrle_pkg::LINES_LOW)) begin
				res.image_height = dbrle_pkg::HEIGHT_LOW;
				if (ff_n == 32'd0) begin
					res.left_offset = dbrle_pkg::LEFT_SHIFT_PIX;
				end
			end else if (lines < LINES_W'(dbrle_pkg::LINES_MID)) begin
				res.image_height = dbrle_pkg::HEIGHT_MID;
			end else if (lines < LINES_W'(dbrle_pkg::LINES_HIGH)) begin
				res.image_height = dbrle_pkg::HEIGHT_HIGH;
			end else begin
				res.image_height = dbrle_pkg::HEIGHT_FULL;
			end
		end
		has_res = res.write_valid || fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= '0;
			prev_q   <= '0;
			rep_q    <= 1'b0;
			wp_q     <= '0;
			stop_q   <= 1'b0;
			ff_q     <= '0;
		end else if (step) begin
			sector_q <= sector_n;
			prev_q   <= prev_n;
			rep_q    <= rep_n;
			wp_q     <= wp_n;
			stop_q   <= stop_n;
			ff_q     <= ff_n;
		end
	end

endmodule
